### rtl/core/mtdm_pkg.sv
`default_nettype none

package mtdm_pkg;

    // Sizing
    localparam int MAX_TARGETS     = 4;
    localparam int SINE_TABLE_BITS = 10;
    localparam int NUM_STEP_REGS   = 4;
    localparam int SMP_W           = 16;
    localparam int PHASE_W         = 32;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 32;
    localparam int COUNT_W         = 3;
    localparam int GAIN_W          = 15;
    localparam int TGT_W           = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
    localparam int CNT_W           = $clog2(MAX_TARGETS + 1);

    // Sine table geometry
    localparam int TABLE_SIZE = 2 ** SINE_TABLE_BITS;
    localparam int QUARTER    = TABLE_SIZE / 4;
    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_STEP0 = CFG_IDX_W'(2);

    // Reset values
    localparam logic [COUNT_W-1:0] COUNT_RST = COUNT_W'(1);
    localparam logic [GAIN_W-1:0]  GAIN_RST  = GAIN_W'(8192);

    typedef struct packed {
        logic signed [SMP_W-1:0] sample_i;
        logic signed [SMP_W-1:0] sample_q;
    } t_in_item;

    typedef struct packed {
        logic signed [SMP_W-1:0] out_i;
        logic signed [SMP_W-1:0] out_q;
    } t_out_item;

    typedef logic [QUARTER:0][SMP_W-1:0] t_quarter_table;

    // Divide by (2n)(2n+1) for the n-th Taylor term
    function automatic logic [63:0] taylor_div(input logic [63:0] v, input int n);
        case (n)
            1:       return v / 64'd6;
            2:       return v / 64'd20;
            3:       return v / 64'd42;
            4:       return v / 64'd72;
            5:       return v / 64'd110;
            6:       return v / 64'd156;
            7:       return v / 64'd210;
            8:       return v / 64'd272;
            9:       return v / 64'd342;
            10:      return v / 64'd420;
            11:      return v / 64'd506;
            default: return v / 64'd600;
        endcase
    endfunction

    // One first-quadrant entry: Taylor series in Q30, scaled to Q1.15
    function automatic logic [SMP_W-1:0] quarter_entry(input int unsigned r);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        int          n;
        x    = (64'd2 * PI_Q30 * 64'(r) + 64'(TABLE_SIZE / 2)) >> SINE_TABLE_BITS;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (n = 1; n <= 12; n++) begin
            term = taylor_div((term * x2) >> 30, n);
            if (n % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        return SMP_W'((64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30);
    endfunction

    function automatic t_quarter_table build_quarter_sine();
        t_quarter_table t;
        for (int k = 0; k <= QUARTER; k++) begin
            t[k] = quarter_entry(k);
        end
        return t;
    endfunction

    localparam t_quarter_table QUARTER_SINE = build_quarter_sine();

    // Full-circle sine from the quarter table by symmetry
    function automatic logic signed [SMP_W-1:0] tbl_sine(
        input logic [SINE_TABLE_BITS-1:0] idx
    );
        logic [1:0]                 quad;
        logic [SINE_TABLE_BITS-3:0] r;
        logic [SINE_TABLE_BITS-2:0] pos;
        logic signed [SMP_W-1:0]    mag;
        quad = idx[SINE_TABLE_BITS-1 -: 2];
        r    = idx[SINE_TABLE_BITS-3:0];
        pos  = quad[0] ? ((SINE_TABLE_BITS - 1)'(QUARTER) - {1'b0, r}) : {1'b0, r};
        mag  = signed'(QUARTER_SINE[pos]);
        return quad[1] ? -mag : mag;
    endfunction

endpackage

`default_nettype wire

### rtl/core/mtdm_ram.sv
`default_nettype none

module mtdm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, read one entry with registered data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/core/multi_target_doppler_mixer.sv
// Each accepted item makes one phase-memory read per enabled target through the
// shared table and multiplier pipeline. The input stays stalled until the result
// is loaded into the output register, so a new item is taken only after the last
// one is done. Reset (synchronous, active low): configuration and control
// registers return to their reset values and all phase accumulators read as zero
// through per-entry valid bits; no clearing pass.
`default_nettype none

module multi_target_doppler_mixer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  mtdm_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output mtdm_pkg::t_out_item                 o_out_item,
    input  logic                                i_cfg_we,
    input  logic [mtdm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [mtdm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import mtdm_pkg::*;

    localparam int PRD_W = 2 * SMP_W + 1;
    localparam int GP_W  = PRD_W + GAIN_W + 1;
    localparam int ACC_W = GP_W + $clog2(MAX_TARGETS);
    localparam int FRAC_SHIFT = 30;
    localparam logic signed [ACC_W:0] RND_HALF = signed'((ACC_W + 1)'(2 ** 29));
    localparam logic signed [ACC_W:0] SAT_MAX  = signed'((ACC_W + 1)'(32767));
    localparam logic signed [ACC_W:0] SAT_MIN  = -signed'((ACC_W + 1)'(32768));

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    // Configuration
    logic [COUNT_W-1:0] r_count;
    logic [GAIN_W-1:0]  r_gain;
    logic [PHASE_W-1:0] r_step [MAX_TARGETS];

    // Control
    logic [1:0]             r_state;
    logic [TGT_W-1:0]       r_tgt;
    logic [CNT_W-1:0]       r_n;
    logic                   r_v1, r_v2, r_v3, r_v4;
    logic [TGT_W-1:0]       r_v1_tgt;
    logic [MAX_TARGETS-1:0] r_ph_vld;
    logic                   r_out_valid;

    // Datapath
    t_in_item                r_smp;
    logic signed [SMP_W-1:0] r_sin, r_cos;
    logic signed [PRD_W-1:0] r_re, r_im;
    logic signed [GP_W-1:0]  r_gi, r_gq;
    logic signed [ACC_W-1:0] r_acc_i, r_acc_q;
    t_out_item               r_out;

    logic                       in_accept;
    logic [CNT_W-1:0]           n_count;
    logic                       pipe_empty;
    logic                       out_load;
    logic                       last_issue;
    logic [PHASE_W-1:0]         ram_rdata;
    logic [PHASE_W-1:0]         cur_phase;
    logic [PHASE_W-1:0]         n_phase;
    logic [SINE_TABLE_BITS-1:0] tbl_idx;
    logic signed [SMP_W-1:0]    n_sin, n_cos;
    logic signed [PRD_W-1:0]    n_re, n_im;
    logic signed [GP_W-1:0]     n_gi, n_gq;
    t_out_item                  n_out;

    function automatic logic signed [SMP_W-1:0] round_sat(
        input logic signed [ACC_W-1:0] a
    );
        logic signed [ACC_W:0] b;
        logic signed [ACC_W:0] s;
        b = (ACC_W + 1)'(a) + RND_HALF;
        s = b >>> FRAC_SHIFT;
        if (s > SAT_MAX)
            return signed'(SMP_W'(32767));
        else if (s < SAT_MIN)
            return signed'(SMP_W'(32768));
        return SMP_W'(s);
    endfunction

    // Clamp the target count to the available targets
    assign n_count = (int'(r_count) > MAX_TARGETS) ? CNT_W'(MAX_TARGETS) : CNT_W'(r_count);

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign pipe_empty = !(r_v1 || r_v2 || r_v3 || r_v4);
    assign out_load   = (r_state == ST_DRAIN) && pipe_empty && (!r_out_valid || !i_out_stall);
    assign last_issue = (int'(r_tgt) == int'(r_n) - 1);

    // Phase memory: read in issue, write back in the following cycle
    mtdm_ram #(
        .WIDTH (PHASE_W),
        .DEPTH (MAX_TARGETS)
    ) u_phase_ram (
        .i_clk   (i_clk),
        .i_we    (r_v1),
        .i_waddr (r_v1_tgt),
        .i_wdata (n_phase),
        .i_raddr (r_tgt),
        .o_rdata (ram_rdata)
    );

    // Stage 1: phase lookup and advance
    assign cur_phase = r_ph_vld[r_v1_tgt] ? ram_rdata : '0;
    assign n_phase   = cur_phase + r_step[r_v1_tgt];
    assign tbl_idx   = cur_phase[PHASE_W-1 -: SINE_TABLE_BITS];
    assign n_sin     = tbl_sine(tbl_idx);
    assign n_cos     = tbl_sine(SINE_TABLE_BITS'(tbl_idx + SINE_TABLE_BITS'(QUARTER)));

    // Stage 2: complex rotation
    assign n_re = PRD_W'(r_smp.sample_i) * PRD_W'(r_cos) - PRD_W'(r_smp.sample_q) * PRD_W'(r_sin);
    assign n_im = PRD_W'(r_smp.sample_i) * PRD_W'(r_sin) + PRD_W'(r_smp.sample_q) * PRD_W'(r_cos);

    // Stage 3: common gain
    assign n_gi = GP_W'(r_re) * GP_W'(signed'({1'b0, r_gain}));
    assign n_gq = GP_W'(r_im) * GP_W'(signed'({1'b0, r_gain}));

    // Output rounding and saturation
    assign n_out.out_i = round_sat(r_acc_i);
    assign n_out.out_q = round_sat(r_acc_q);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_RST;
            r_gain  <= GAIN_RST;
            for (int k = 0; k < MAX_TARGETS; k++) begin
                r_step[k] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_COUNT) begin
                r_count <= i_cfg_data[COUNT_W-1:0];
            end
            if (i_cfg_idx == REG_GAIN) begin
                r_gain <= i_cfg_data[GAIN_W-1:0];
            end
            for (int k = 0; k < MAX_TARGETS; k++) begin
                if (k < NUM_STEP_REGS && int'(i_cfg_idx) == int'(REG_STEP0) + k) begin
                    r_step[k] <= i_cfg_data[PHASE_W-1:0];
                end
            end
        end
    end

    // Sequencer and pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tgt       <= '0;
            r_n         <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_v1_tgt    <= '0;
            r_ph_vld    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1     <= (r_state == ST_ISSUE);
            r_v1_tgt <= r_tgt;
            r_v2     <= r_v1;
            r_v3     <= r_v2;
            r_v4     <= r_v3;
            if (r_v1) begin
                r_ph_vld[r_v1_tgt] <= 1'b1;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_tgt   <= '0;
                        r_n     <= n_count;
                        r_state <= (n_count == '0) ? ST_DRAIN : ST_ISSUE;
                    end
                end
                ST_ISSUE: begin
                    if (last_issue) begin
                        r_state <= ST_DRAIN;
                    end else begin
                        r_tgt <= r_tgt + TGT_W'(1);
                    end
                end
                ST_DRAIN: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            // Hold the result until taken
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_smp   <= i_in_item;
            r_acc_i <= '0;
            r_acc_q <= '0;
        end else if (r_v4) begin
            r_acc_i <= r_acc_i + ACC_W'(r_gi);
            r_acc_q <= r_acc_q + ACC_W'(r_gq);
        end
        r_sin <= n_sin;
        r_cos <= n_cos;
        r_re  <= n_re;
        r_im  <= n_im;
        r_gi  <= n_gi;
        r_gq  <= n_gq;
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // The block takes an item only with the pipeline empty
    a_accept_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> pipe_empty)
        else $error("item accepted with targets still in flight");

    // An accepted item closes the input until its result is formed
    a_accept_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_in_stall)
        else $error("input not stalled after accept");

    // Write-back only touches enabled targets
    a_wb_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> (int'(r_v1_tgt) < int'(r_n)))
        else $error("phase write-back beyond enabled targets");

endmodule

`default_nettype wire

### sim/multi_target_doppler_mixer_tb.sv
`timescale 1ns / 100ps

import mtdm_pkg::*;

// Predicts the mixer output per accepted sample and compares results in order
class mixer_scoreboard;
    logic signed [SMP_W-1:0] quarter_sine [QUARTER+1];
    bit [COUNT_W-1:0]        count_reg;
    bit [GAIN_W-1:0]         gain_reg;
    bit [PHASE_W-1:0]        step_reg  [MAX_TARGETS];
    bit [PHASE_W-1:0]        phase_acc [MAX_TARGETS];
    t_out_item               expected_mix_q [$];
    int                      errors;
    int                      checked;

    function new();
        for (int k = 0; k <= QUARTER; k++) begin
            quarter_sine[k] = first_quadrant(k);
        end
        count_reg = COUNT_RST;
        gain_reg  = GAIN_RST;
        for (int k = 0; k < MAX_TARGETS; k++) begin
            step_reg[k]  = '0;
            phase_acc[k] = '0;
        end
        errors  = 0;
        checked = 0;
    endfunction

    // Taylor series for sin in Q30 over the first quadrant, scaled to Q1.15
    function logic signed [SMP_W-1:0] first_quadrant(int unsigned r);
        bit [63:0] x;
        bit [63:0] x2;
        bit [63:0] term;
        longint    acc;
        x    = (64'd2 * PI_Q30 * 64'(r) + 64'(TABLE_SIZE / 2)) / 64'(TABLE_SIZE);
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 12; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        return SMP_W'((acc * 32767 + (longint'(1) << 29)) >>> 30);
    endfunction

    // Full circle by quadrant symmetry
    function logic signed [SMP_W-1:0] table_sine(bit [SINE_TABLE_BITS-1:0] idx);
        bit [SINE_TABLE_BITS-3:0] r;
        r = idx[SINE_TABLE_BITS-3:0];
        case (idx[SINE_TABLE_BITS-1 -: 2])
            2'd0:    return quarter_sine[r];
            2'd1:    return quarter_sine[QUARTER - r];
            2'd2:    return -quarter_sine[r];
            default: return -quarter_sine[QUARTER - r];
        endcase
    endfunction

    // Round half up out of Q30, then clamp to 16 bits
    function logic signed [SMP_W-1:0] round_sat(longint v);
        longint r;
        r = (v + (longint'(1) << 29)) >>> 30;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return SMP_W'(r);
    endfunction

    function void note_config(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] data);
        int t;
        t = int'(idx) - int'(REG_STEP0);
        if (idx == REG_COUNT)
            count_reg = data[COUNT_W-1:0];
        else if (idx == REG_GAIN)
            gain_reg = data[GAIN_W-1:0];
        else if (t >= 0 && t < NUM_STEP_REGS && t < MAX_TARGETS)
            step_reg[t] = data[PHASE_W-1:0];
    endfunction

    function void predict_mix(t_in_item it);
        longint                   si;
        longint                   sq;
        longint                   s;
        longint                   c;
        longint                   gain;
        longint                   acc_i;
        longint                   acc_q;
        int                       n;
        bit [SINE_TABLE_BITS-1:0] idx;
        t_out_item                res;
        si    = longint'($signed(it.sample_i));
        sq    = longint'($signed(it.sample_q));
        gain  = longint'(gain_reg);
        acc_i = 0;
        acc_q = 0;
        n     = (count_reg > MAX_TARGETS) ? MAX_TARGETS : int'(count_reg);
        // Sum the rotated, scaled sample over the enabled targets
        for (int k = 0; k < n; k++) begin
            idx   = phase_acc[k][PHASE_W-1 -: SINE_TABLE_BITS];
            s     = longint'(table_sine(idx));
            c     = longint'(table_sine(SINE_TABLE_BITS'(idx + QUARTER)));
            acc_i = acc_i + (si * c - sq * s) * gain;
            acc_q = acc_q + (si * s + sq * c) * gain;
        end
        // Advance enabled accumulators after the output is formed
        for (int k = 0; k < n; k++) begin
            phase_acc[k] = phase_acc[k] + step_reg[k];
        end
        res.out_i = round_sat(acc_i);
        res.out_q = round_sat(acc_q);
        expected_mix_q.push_back(res);
    endfunction

    function void check_mix(t_out_item got);
        t_out_item want;
        if (expected_mix_q.size() == 0) begin
            errors++;
            if (errors <= 40)
                $display("%0t: unexpected result i=%0d q=%0d", $time,
                         $signed(got.out_i), $signed(got.out_q));
            return;
        end
        want = expected_mix_q.pop_front();
        checked++;
        if (got.out_i !== want.out_i) begin
            errors++;
            if (errors <= 40)
                $display("%0t: out_i mismatch, expected %0d, got %0d", $time,
                         $signed(want.out_i), $signed(got.out_i));
        end
        if (got.out_q !== want.out_q) begin
            errors++;
            if (errors <= 40)
                $display("%0t: out_q mismatch, expected %0d, got %0d", $time,
                         $signed(want.out_q), $signed(got.out_q));
        end
    endfunction

    function int pending();
        return expected_mix_q.size();
    endfunction
endclass

module multi_target_doppler_mixer_tb;
    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int END_CYCLES   = 20;
    localparam int PHASES       = 14;
    localparam int PHASE_ITEMS  = 100;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(REG_STEP0 + NUM_STEP_REGS);

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_item  = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_item;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    mixer_scoreboard sb = new();
    bit              idle_on = 1'b1;
    int              hold_cycles = 0;
    int              cycle_count = 0;
    int              samples_in = 0;
    int              settings_done = 0;

    multi_target_doppler_mixer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Predict each accepted sample
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            sb.predict_mix(i_in_item);
            samples_in++;
        end
    end

    // Check each accepted result, then draw the next stall stretch
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_mix(o_out_item);
            hold_cycles = idle_on ? $urandom_range(0, 19) : 0;
            i_out_stall <= (hold_cycles != 0);
        end else if (hold_cycles > 0) begin
            hold_cycles--;
            i_out_stall <= (hold_cycles != 0);
        end
    end

    function automatic t_in_item sample_of(logic [SMP_W-1:0] si, logic [SMP_W-1:0] sq);
        t_in_item it;
        it.sample_i = si;
        it.sample_q = sq;
        return it;
    endfunction

    function automatic logic [SMP_W-1:0] extreme_value();
        return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    endfunction

    function automatic t_in_item rand_sample();
        t_in_item it;
        it = $urandom();
        case ($urandom_range(0, 9))
            6: it = sample_of(extreme_value(), extreme_value());
            7: it = sample_of(SMP_W'($urandom_range(0, 64)) - 16'd32,
                              SMP_W'($urandom_range(0, 64)) - 16'd32);
            8: it.sample_q = '0;
            9: it.sample_i = extreme_value();
            default: ;
        endcase
        return it;
    endfunction

    function automatic logic [PHASE_W-1:0] rand_step();
        case ($urandom_range(0, 7))
            4:       return PHASE_W'(int'($urandom_range(0, 8192)) - 4096);
            5:       return PHASE_W'($urandom_range(0, TABLE_SIZE - 1)) << (PHASE_W - SINE_TABLE_BITS);
            6:       return '0;
            7:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Present one item after a random gap (none when idle_on is clear) and hold it until accepted
    task automatic send_sample(input t_in_item it);
        int gap;
        gap = idle_on ? $urandom_range(0, 19) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Hold the sender until every predicted result has been checked
    task automatic wait_results_done();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.note_config(idx, data);
    endtask

    // Drain, let the pipeline settle, then load every register
    task automatic apply_setting(
        input logic [COUNT_W-1:0]                    cnt,
        input logic [GAIN_W-1:0]                     gain,
        input logic [NUM_STEP_REGS-1:0][PHASE_W-1:0] steps,
        input bit                                    junk
    );
        logic [CFG_DATA_W-1:0] cdata;
        logic [CFG_DATA_W-1:0] gdata;
        cdata = CFG_DATA_W'(cnt);
        gdata = CFG_DATA_W'(gain);
        if (junk) begin
            cdata = ($urandom() << COUNT_W) | cdata;
            gdata = ($urandom() << GAIN_W) | gdata;
        end
        wait_results_done();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        write_reg(REG_COUNT, cdata);
        write_reg(REG_GAIN, gdata);
        for (int k = 0; k < NUM_STEP_REGS; k++) begin
            write_reg(CFG_IDX_W'(REG_STEP0 + k), steps[k]);
        end
        // Unmapped indexes must leave every register alone
        if (junk) begin
            write_reg(REG_SPARE, $urandom());
            write_reg(REG_SPARE + 1'b1, $urandom());
        end
        i_cfg_we <= 1'b0;
        settings_done++;
    endtask

    initial begin
        logic [NUM_STEP_REGS-1:0][PHASE_W-1:0] steps;
        logic [COUNT_W-1:0]                    cnt;
        logic [GAIN_W-1:0]                     gain;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: one target, static phase
        send_sample(sample_of(16'h8000, 16'h8000));
        send_sample(sample_of(16'h7FFF, 16'h7FFF));
        send_sample(sample_of(16'h0000, 16'h0000));
        send_sample(sample_of(16'h8000, 16'h7FFF));
        send_sample(sample_of(16'h7FFF, 16'h8000));

        // Four targets at full gain: saturation and wrapping steps
        apply_setting(3'd4, 15'd32767,
                      {32'h7FFF_FFFF, 32'hFFC0_0000, 32'h8000_0000, 32'h4000_0000}, 1'b0);
        send_sample(sample_of(16'h7FFF, 16'h7FFF));
        send_sample(sample_of(16'h8000, 16'h8000));
        send_sample(sample_of(16'h7FFF, 16'h8000));
        send_sample(sample_of(16'h8000, 16'h7FFF));
        send_sample(sample_of(16'h0001, 16'hFFFF));
        send_sample(sample_of(16'h4000, 16'hC000));

        // No targets: output is zero, phases frozen
        apply_setting(3'd0, 15'd32767,
                      {32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 32'h0100_0000}, 1'b0);
        send_sample(sample_of(16'h7FFF, 16'h8000));
        send_sample(sample_of(16'h1234, 16'hFFFF));

        // Count above the target limit, minimum gain, junk in unused bits
        apply_setting(3'd7, 15'd1,
                      {32'h0040_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0040_0000}, 1'b1);
        send_sample(sample_of(16'h8000, 16'h8000));
        send_sample(sample_of(16'h7FFF, 16'h7FFF));
        send_sample(sample_of(16'h0001, 16'h0000));

        // Zero gain with two targets; the other two hold their phase
        apply_setting(3'd2, 15'd0,
                      {32'h1234_5678, 32'h9ABC_DEF0, 32'h0C00_0000, 32'hF400_0000}, 1'b0);
        send_sample(sample_of(16'h7FFF, 16'h7FFF));
        send_sample(sample_of(16'h8000, 16'h0000));

        // Three targets pick up where they stopped
        apply_setting(3'd3, 15'd32767,
                      {32'h0000_0000, 32'h0300_0000, 32'hFF00_0000, 32'h0100_0000}, 1'b1);
        repeat (5) send_sample(sample_of(extreme_value(), extreme_value()));

        // Random phases, each with its own register setting
        for (int p = 0; p < PHASES; p++) begin
            for (int k = 0; k < NUM_STEP_REGS; k++) begin
                steps[k] = rand_step();
            end
            case (p)
                0: begin cnt = 3'd4; gain = 15'd32767; end
                1: begin cnt = 3'd0; gain = GAIN_W'($urandom()); end
                2: begin cnt = 3'd7; gain = 15'd0; end
                3: begin cnt = 3'd1; gain = GAIN_W'($urandom()); end
                default: begin
                    cnt  = ($urandom_range(0, 9) < 8) ? COUNT_W'($urandom_range(1, 4))
                                                      : COUNT_W'($urandom_range(0, 7));
                    gain = ($urandom_range(0, 3) == 0) ? 15'd32767 : GAIN_W'($urandom());
                end
            endcase
            apply_setting(cnt, gain, steps, 1'($urandom_range(0, 1)));
            idle_on = (p % 4 != 2);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p % 3 == 0 && i == PHASE_ITEMS / 2)
                    wait_results_done();
                send_sample(rand_sample());
            end
        end

        // Let the last results come out
        wait_results_done();
        repeat (END_CYCLES) @(posedge i_clk);

        $display("Covered %0d samples over %0d register settings, %0d results compared.",
                 samples_in, settings_done, sb.checked);
        $display("Included target counts 0 to 7, gain and sample extremes, wrapping steps.");
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

### files.f
rtl/core/mtdm_pkg.sv
rtl/core/mtdm_ram.sv
rtl/core/multi_target_doppler_mixer.sv
sim/multi_target_doppler_mixer_tb.sv
